// ===== hdl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// shared constants and types for the point-in-polygon test block
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 7;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int VERT_W       = 2 * COORD_BITS;

  // tdata: vertex_index, coord_x, coord_y from bit 0 up, padded to bytes
  localparam int IN_FIELD_W   = ADDR_W + 2 * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

endpackage

// ===== hdl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// crossing-parity point-in-polygon test over a vertex table loaded by index
// ----------------------------------------------------------------------------
// load request: writes one vertex into the table, no result
// test request: fetch the closing vertex, then evaluate each edge, with a
//   second step for each edge that straddles the query y (shared multiplier
//   used twice), then move the result to the output register
// one request in work at a time; a finished result waits in the output reg
// reset clears control and vertex_count; the vertex table is not cleared
// ----------------------------------------------------------------------------
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,     // vertex_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // vertex_index, coord_x, coord_y
  input  logic                   s_axis_tuser,    // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata     // inside_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_EVAL,
    ST_MUL2,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  vertex_count_q;
  logic [ADDR_W-1:0] idx_q;
  logic [ADDR_W-1:0] last_q;
  coord_t            tx_q, ty_q;
  coord_t            prev_x_q, prev_y_q;
  prod_t             p1_q;
  logic              parity_q;
  logic              out_valid_q;
  logic              out_res_q;

  logic              in_accept;
  logic [ADDR_W-1:0] in_index;
  coord_t            in_x, in_y;
  logic [CNT_W-1:0]  n_used;
  logic [ADDR_W-1:0] n_last;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VERT_W-1:0] ram_rdata;

  coord_t            cur_x, cur_y;
  diff_t             dy, mul_a, mul_b;
  prod_t             product;
  logic              straddle, left, last_edge;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_index  = s_axis_tdata[ADDR_W-1:0];
  assign in_x      = s_axis_tdata[ADDR_W +: COORD_BITS];
  assign in_y      = s_axis_tdata[ADDR_W+COORD_BITS +: COORD_BITS];

  assign n_used = (vertex_count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : vertex_count_q;
  assign n_last = ADDR_W'(n_used - CNT_W'(1));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign ram_we        = in_accept && (s_axis_tuser == OP_LOAD);

  pip_ram #(
    .WIDTH(VERT_W),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_index),
    .wdata_i({in_y, in_x}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // edge from vertex i (cur) to vertex i-1 (prev)
  assign cur_x     = ram_rdata[COORD_BITS-1:0];
  assign cur_y     = ram_rdata[VERT_W-1:COORD_BITS];
  assign straddle  = (cur_y > ty_q) != (prev_y_q > ty_q);
  assign dy        = diff_t'(prev_y_q) - diff_t'(cur_y);
  assign last_edge = (idx_q == last_q);

  // shared multiplier
  always_comb begin
    if (state_q == ST_MUL2) begin
      mul_a = diff_t'(prev_x_q) - diff_t'(cur_x);
      mul_b = diff_t'(ty_q) - diff_t'(cur_y);
    end else begin
      mul_a = diff_t'(tx_q) - diff_t'(cur_x);
      mul_b = dy;
    end
  end

  assign product = prod_t'(mul_a) * prod_t'(mul_b);
  assign left    = dy[DIFF_W-1] ? (p1_q > product) : (p1_q < product);

  // vertex read sequencing
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q + ADDR_W'(1);
    case (state_q)
      ST_IDLE: begin
        ram_raddr = n_last;
        ram_re    = in_accept && (s_axis_tuser == OP_TEST);
      end
      ST_LAST: begin
        ram_raddr = idx_q;
        ram_re    = 1'b1;
      end
      ST_EVAL: begin
        ram_re = !straddle && !last_edge;
      end
      ST_MUL2: begin
        ram_re = !last_edge;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      vertex_count_q <= '0;
      idx_q          <= '0;
      last_q         <= '0;
      parity_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_res_q      <= 1'b0;
      tx_q           <= '0;
      ty_q           <= '0;
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      p1_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        vertex_count_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept && (s_axis_tuser == OP_TEST)) begin
            tx_q     <= in_x;
            ty_q     <= in_y;
            idx_q    <= '0;
            last_q   <= n_last;
            parity_q <= 1'b0;
            state_q  <= (n_used == '0) ? ST_DONE : ST_LAST;
          end
        end
        ST_LAST: begin
          prev_x_q <= cur_x;
          prev_y_q <= cur_y;
          state_q  <= ST_EVAL;
        end
        ST_EVAL: begin
          if (straddle) begin
            p1_q    <= product;
            state_q <= ST_MUL2;
          end else begin
            prev_x_q <= cur_x;
            prev_y_q <= cur_y;
            idx_q    <= idx_q + ADDR_W'(1);
            state_q  <= last_edge ? ST_DONE : ST_EVAL;
          end
        end
        ST_MUL2: begin
          if (left) begin
            parity_q <= !parity_q;
          end
          prev_x_q <= cur_x;
          prev_y_q <= cur_y;
          idx_q    <= idx_q + ADDR_W'(1);
          state_q  <= last_edge ? ST_DONE : ST_EVAL;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_res_q   <= parity_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_res_q};

endmodule

// ===== hdl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
